// ===== design/sbus_frame_receiver_top_assert.svh =====
// Assertion macros for the SBUS frame receiver
`ifndef SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SBUSFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SBUSFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sbusfr_pkg.sv =====
package sbusfr_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 25;
  localparam int STORE_BYTES = FRAME_BYTES - 1;
  localparam int CHANNELS    = 16;
  localparam int CH_W        = 11;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int CHAN_IDX_W  = $clog2(CHANNELS);
  localparam int TICK_W      = 16;

  // flag bits in the last stored byte
  localparam int LOST_BIT     = 2;
  localparam int FAILSAFE_BIT = 3;

  // value returned for a channel number outside 1..16
  localparam logic [CH_W-1:0] CENTER_VALUE = 11'd992;

  // item kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // result kinds
  localparam logic REPORT_FRAME = 1'b0;
  localparam logic REPORT_READ  = 1'b1;

  // register indexes
  localparam logic [1:0] CFG_START   = 2'd0;
  localparam logic [1:0] CFG_END     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  // register reset values
  localparam logic [7:0]        START_RESET   = 8'd15;
  localparam logic [7:0]        END_RESET     = 8'd0;
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd30;

  typedef logic [7:0] byte_t;
  typedef logic [CH_W-1:0] chan_t;

endpackage

// ===== design/sbusfr_cell.sv =====
// One byte stage of the frame shift line
module sbusfr_cell (
  input  logic                clk,
  input  logic                shift,
  input  sbusfr_pkg::byte_t   d,
  output sbusfr_pkg::byte_t   q
);

  sbusfr_pkg::byte_t data;

  // take the neighbour's byte when the line advances
  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

// ===== design/sbus_frame_receiver_top.sv =====
// Channel   Valid      Stall      Payload
// ------------------------------------------------------------------------
// input     in_valid   in_stall   kind, byte_value, channel_number
// output    out_valid  out_stall  report_kind, frame_accepted, channel_value,
//                                 data_valid, lost_frame, failsafe
// config    cfg_write  -          cfg_index, cfg_data
//
// One item per cycle while in_stall is low; a result appears on the output register
// in the cycle after the item that causes it. Frame bytes travel down a row of 24 byte
// cells, so the unpack at the closing byte is wiring over the cells.
// Reset is synchronous and clears position, channels, flags, counter, out_valid and the
// configuration registers; the byte cells and the output payload hold no reset value.
// in_stall is high only while a result waits in the output register and
// out_stall is high.
module sbus_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic [4:0]  channel_number,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        report_kind,
  output logic        frame_accepted,
  output logic [10:0] channel_value,
  output logic        data_valid,
  output logic        lost_frame,
  output logic        failsafe,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NB = sbusfr_pkg::STORE_BYTES;
  localparam int NC = sbusfr_pkg::CHANNELS;
  localparam int CW = sbusfr_pkg::CH_W;
  localparam int PW = sbusfr_pkg::POS_W;
  localparam int TW = sbusfr_pkg::TICK_W;
  localparam int FLAT_W = (NB - 2) * 8;

  // configuration registers
  logic [7:0]    start_byte;
  logic [7:0]    end_byte;
  logic [TW-1:0] timeout_ticks;

  // block state
  logic [PW-1:0]        byte_position;
  sbusfr_pkg::chan_t    channel_store [NC];
  logic                 lost_flag;
  logic                 failsafe_flag;
  logic                 valid_flag;
  logic [TW-1:0]        elapsed_ticks;

  // byte cells, cell 0 holds the newest byte
  sbusfr_pkg::byte_t cell_q [NB];
  logic              shift;

  logic              accept;
  logic              is_byte;
  logic              is_tick;
  logic              is_read;
  logic              is_start;
  logic              collecting;
  logic              closing;
  logic              end_match;
  logic              good_frame;
  logic [FLAT_W-1:0] flat;
  logic              lost_new;
  logic              failsafe_new;
  logic              lost_next;
  logic              failsafe_next;
  logic              valid_next;
  logic [TW-1:0]     elapsed_inc;
  logic              chn_in_range;
  logic [4:0]        chn_m1;
  logic [sbusfr_pkg::CHAN_IDX_W-1:0] chn_idx;
  sbusfr_pkg::chan_t read_value;
  logic              result_gen;

  // item decode
  assign in_stall   = out_valid && out_stall;
  assign accept     = in_valid && !in_stall;
  assign is_byte    = accept && (kind == sbusfr_pkg::KIND_BYTE);
  assign is_tick    = accept && (kind == sbusfr_pkg::KIND_TICK);
  assign is_read    = accept && (kind == sbusfr_pkg::KIND_READ);
  assign is_start   = byte_value == start_byte;
  assign collecting = (byte_position != '0) && (byte_position < PW'(NB));
  assign closing    = is_byte && !is_start && (byte_position == PW'(NB));
  assign end_match  = byte_value == end_byte;
  assign good_frame = closing && end_match;
  assign shift      = is_byte && (is_start || collecting);
  assign result_gen = closing || is_read;

  // row of byte cells
  for (genvar k = 0; k < NB; k++) begin : g_cell
    if (k == 0) begin : g_head
      sbusfr_cell u_cell (.clk(clk), .shift(shift), .d(byte_value), .q(cell_q[k]));
    end else begin : g_body
      sbusfr_cell u_cell (.clk(clk), .shift(shift), .d(cell_q[k-1]), .q(cell_q[k]));
    end
  end

  // frame bytes 1..22 laid out LSB first; byte j sits in cell NB-1-j
  for (genvar j = 1; j <= NB - 2; j++) begin : g_flat
    assign flat[8*(j-1) +: 8] = cell_q[NB-1-j];
  end

  // flags from the last stored byte, which is in cell 0 at the closing byte
  assign lost_new     = cell_q[0][sbusfr_pkg::LOST_BIT];
  assign failsafe_new = cell_q[0][sbusfr_pkg::FAILSAFE_BIT];

  // saturating tick counter
  assign elapsed_inc = (elapsed_ticks == {TW{1'b1}}) ? elapsed_ticks
                                                     : elapsed_ticks + TW'(1);

  // next status flags
  always_comb begin
    lost_next     = lost_flag;
    failsafe_next = failsafe_flag;
    valid_next    = valid_flag;
    if (good_frame) begin
      lost_next     = lost_new;
      failsafe_next = failsafe_new;
      valid_next    = !lost_new && !failsafe_new;
    end else if (is_tick && (elapsed_inc > timeout_ticks)) begin
      valid_next = 1'b0;
    end
  end

  // channel read
  assign chn_in_range = (channel_number != 5'd0) && (channel_number <= 5'(NC));
  assign chn_m1       = channel_number - 5'd1;
  assign chn_idx      = chn_m1[sbusfr_pkg::CHAN_IDX_W-1:0];
  assign read_value   = chn_in_range ? channel_store[chn_idx] : sbusfr_pkg::CENTER_VALUE;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte    <= sbusfr_pkg::START_RESET;
      end_byte      <= sbusfr_pkg::END_RESET;
      timeout_ticks <= sbusfr_pkg::TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        sbusfr_pkg::CFG_START:   start_byte    <= cfg_data[7:0];
        sbusfr_pkg::CFG_END:     end_byte      <= cfg_data[7:0];
        sbusfr_pkg::CFG_TIMEOUT: timeout_ticks <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  // frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (is_byte) begin
      if (is_start) begin
        byte_position <= PW'(1);
      end else if (collecting) begin
        byte_position <= byte_position + PW'(1);
      end else begin
        byte_position <= '0;
      end
    end
  end

  // unpacked channels, loaded on a good frame
  for (genvar c = 0; c < NC; c++) begin : g_chan
    always_ff @(posedge clk) begin
      if (rst) begin
        channel_store[c] <= '0;
      end else if (good_frame) begin
        channel_store[c] <= flat[c*CW +: CW];
      end
    end
  end

  // status flags and tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_flag     <= 1'b0;
      failsafe_flag <= 1'b0;
      valid_flag    <= 1'b0;
      elapsed_ticks <= '0;
    end else begin
      lost_flag     <= lost_next;
      failsafe_flag <= failsafe_next;
      valid_flag    <= valid_next;
      if (good_frame) begin
        elapsed_ticks <= '0;
      end else if (is_tick) begin
        elapsed_ticks <= elapsed_inc;
      end
    end
  end

  // output register: valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_gen) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (result_gen) begin
      report_kind    <= is_read ? sbusfr_pkg::REPORT_READ : sbusfr_pkg::REPORT_FRAME;
      frame_accepted <= good_frame;
      channel_value  <= is_read ? read_value : '0;
      data_valid     <= valid_next;
      lost_frame     <= lost_next;
      failsafe       <= failsafe_next;
    end
  end

  // checks
  `include "sbus_frame_receiver_top_assert.svh"

  `SBUSFR_ASSERT_NOW(a_pos_range, 1'b1, byte_position <= PW'(NB), "frame position beyond last stored byte")
  `SBUSFR_ASSERT_NOW(a_valid_flags, valid_flag, !lost_flag && !failsafe_flag, "valid set with lost or failsafe flag")
  `SBUSFR_ASSERT_NEXT(a_close_report, closing, out_valid && (report_kind == sbusfr_pkg::REPORT_FRAME), "closing byte gave no frame report")
  `SBUSFR_ASSERT_NEXT(a_good_clears, good_frame, (elapsed_ticks == '0) && (byte_position == '0), "good frame did not clear counter and position")
  `SBUSFR_ASSERT_NEXT(a_read_answer, is_read, out_valid && (report_kind == sbusfr_pkg::REPORT_READ) && !frame_accepted, "read gave no read answer")

endmodule
